/* hdl/sharpen_3x3_convolution_unit_assert.svh */
// assertion macros for the sharpen convolution unit
`ifndef SHARPEN_3X3_CONVOLUTION_UNIT_ASSERT_SVH
`define SHARPEN_3X3_CONVOLUTION_UNIT_ASSERT_SVH

// same-cycle implication
`define SHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/shp_pkg.sv */
// shared constants for the sharpen convolution unit
`default_nettype none

package shp_pkg;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned CFG_W       = 12;
    localparam int unsigned ROW_W       = 12;
    localparam int unsigned COL_W       = 12;
    localparam int unsigned OUT_COL_W   = 11;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned MAX_WIDTH_DEF = 2048;

    localparam logic [CFG_W-1:0] MIN_DIM        = 12'd3;
    localparam logic [CFG_W-1:0] MAX_HEIGHT     = 12'd4095;
    localparam logic [CFG_W-1:0] WIDTH_RESET    = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET   = 12'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

endpackage

`default_nettype wire

/* hdl/shp_in_if.sv */
// input pixel channel
`default_nettype none

interface shp_in_if
    import shp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

/* hdl/shp_out_if.sv */
// filtered pixel channel
`default_nettype none

interface shp_out_if
    import shp_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     sharpened;
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;

    modport source (output valid, output sharpened, output out_row, output out_col,
                    input ready);
    modport sink   (input valid, input sharpened, input out_row, input out_col,
                    output ready);
endinterface

`default_nettype wire

/* hdl/shp_ram.sv */
// simple dual-port ram with registered read
`default_nettype none

module shp_ram
    import shp_pkg::*;
#(
    parameter int unsigned WIDTH = PIX_W,
    parameter int unsigned DEPTH = MAX_WIDTH_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/sharpen_3x3_convolution_unit.sv */
// 3x3 laplacian sharpen filter over a raster pixel stream
//
//  channel  | dir | payload                            | handshake
//  ---------+-----+------------------------------------+-------------
//  i_pix    | in  | pixel[7:0], frame_start            | valid/ready
//  o_res    | out | sharpened[7:0], out_row, out_col   | valid/ready
//  i_cfg_*  | in  | idx 0 image_width, 1 image_height  | write enable
//
//  one pixel per clock sustained while the output is not stalled; a result is
//  registered after its pixel passes the filter stage (line store read at the
//  accept edge, filter and output register when the filter stage advances)
//  line store read-modify-write overlaps, covered by forwarding
//  an output stall holds the filter stage only when it carries a result
//  synchronous active-low reset; line stores are not cleared
`default_nettype none

module sharpen_3x3_convolution_unit
    import shp_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    shp_in_if.sink                    i_pix,
    shp_out_if.source                 o_res
);

`include "sharpen_3x3_convolution_unit_assert.svh"

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CFG_W+1:0] MAXW_L = (CFG_W+2)'(MAX_WIDTH);

    // configuration
    logic [CFG_W-1:0] r_width, r_height;
    logic [CFG_W-1:0] eff_w, eff_h;

    // position
    logic [COL_W-1:0] r_col, c_cur;
    logic [ROW_W-1:0] r_row, r_cur;
    logic [COL_W:0]   c_inc;
    logic [ROW_W:0]   r_inc;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [AW+COL_W-1:0] idx_wide;
    logic [AW-1:0]       rd_idx;
    logic                res_now;
    logic                in_accept;

    // filter stage
    logic             r_s1_valid, r_s1_res;
    logic [PIX_W-1:0] r_s1_pix;
    logic [AW-1:0]    r_s1_idx;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             s1_adv, s1_wr;

    // forwarding of a same-entry write
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_a, r_fwd_b;
    logic [PIX_W-1:0] ram_a_q, ram_b_q, up1, up2;

    // window columns: left-middle, top, centre, bottom
    logic [PIX_W-1:0] r_win_l, r_win_t, r_win_c, r_win_b;

    // arithmetic
    logic [10:0] c5;
    logic [9:0]  nsum;
    logic [11:0] diff;
    logic [PIX_W-1:0] sat;

    // output register
    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_pix;
    logic [ROW_W-1:0]     r_out_row;
    logic [OUT_COL_W-1:0] r_out_col;

    // effective size, saturated
    always_comb begin
        priority if (r_width < MIN_DIM) begin
            eff_w = MIN_DIM;
        end else if ({2'b00, r_width} > MAXW_L) begin
            eff_w = MAXW_L[CFG_W-1:0];
        end else begin
            eff_w = r_width;
        end
        priority if (r_height < MIN_DIM) begin
            eff_h = MIN_DIM;
        end else if (r_height > MAX_HEIGHT) begin
            eff_h = MAX_HEIGHT;
        end else begin
            eff_h = r_height;
        end
    end

    always_comb begin
        c_cur = i_pix.frame_start ? '0 : r_col;
        r_cur = i_pix.frame_start ? '0 : r_row;
        c_inc = {1'b0, c_cur} + 1'b1;
        r_inc = {1'b0, r_cur} + 1'b1;
        n_col = c_inc[COL_W-1:0];
        n_row = r_cur;
        if (c_inc >= {1'b0, eff_w}) begin
            n_col = '0;
            n_row = (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[ROW_W-1:0];
        end
        idx_wide = {{AW{1'b0}}, c_cur};
        rd_idx   = idx_wide[AW-1:0];
        res_now  = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2)) &&
                   (r_cur < eff_h) && (c_cur < eff_w);
    end

    assign s1_adv      = !r_s1_res || !r_out_valid || o_res.ready;
    assign s1_wr       = r_s1_valid && s1_adv;
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_accept   = i_pix.valid && i_pix.ready;

    shp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (s1_wr),
        .i_waddr (r_s1_idx),
        .i_wdata (r_s1_pix),
        .i_re    (in_accept),
        .i_raddr (rd_idx),
        .o_rdata (ram_a_q)
    );

    shp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (s1_wr),
        .i_waddr (r_s1_idx),
        .i_wdata (up1),
        .i_re    (in_accept),
        .i_raddr (rd_idx),
        .o_rdata (ram_b_q)
    );

    assign up1 = r_fwd ? r_fwd_a : ram_a_q;
    assign up2 = r_fwd ? r_fwd_b : ram_b_q;

    // 5*centre - top - bottom - left - right, clamped
    always_comb begin
        c5   = ({3'b000, r_win_c} << 2) + {3'b000, r_win_c};
        nsum = {2'b00, r_win_t} + {2'b00, r_win_b} + {2'b00, r_win_l} + {2'b00, up1};
        diff = {1'b0, c5} - {2'b00, nsum};
        priority if (diff[11]) begin
            sat = '0;
        end else if (|diff[10:8]) begin
            sat = '1;
        end else begin
            sat = diff[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_res    <= 1'b0;
            r_fwd       <= 1'b0;
            r_win_l     <= '0;
            r_win_t     <= '0;
            r_win_c     <= '0;
            r_win_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_accept) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_s1_res <= res_now;
                // entry written this edge is read this edge too
                r_fwd    <= s1_wr && (r_s1_idx == rd_idx);
                r_fwd_a  <= r_s1_pix;
                r_fwd_b  <= up1;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_wr) begin
                r_win_l <= r_win_c;
                r_win_t <= up2;
                r_win_c <= up1;
                r_win_b <= r_s1_pix;
            end

            if (s1_wr && r_s1_res) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pix <= i_pix.pixel;
            r_s1_idx <= rd_idx;
            r_s1_col <= c_cur;
            r_s1_row <= r_cur;
        end
        if (s1_wr && r_s1_res) begin
            r_out_pix <= sat;
            r_out_row <= r_s1_row - 1'b1;
            r_out_col <= OUT_COL_W'(r_s1_col - 1'b1);
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.sharpened = r_out_pix;
    assign o_res.out_row   = r_out_row;
    assign o_res.out_col   = r_out_col;

    `SHP_ASSERT_IMP(a_out_interior, i_clk, i_rst_n, r_out_valid,
        (r_out_row != '0) && (r_out_col != '0), "border pixel emitted")
    `SHP_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, r_s1_valid && r_s1_res && s1_adv,
        r_out_valid, "filter result lost")
    `SHP_ASSERT_NEXT(a_stage_hold, i_clk, i_rst_n, r_s1_valid && !s1_adv,
        r_s1_valid && $stable(r_s1_col) && $stable(r_s1_row), "stalled stage moved")

endmodule

`default_nettype wire
